FILE: rtl/mrs_pkg.sv
`timescale 1ns / 1ps

package mrs_pkg;

	// Modbus function codes served by the responder
	localparam logic [7:0] FN_READ_COILS  = 8'h01;
	localparam logic [7:0] FN_READ_INPUTS = 8'h02;
	localparam logic [7:0] FN_READ_REGS   = 8'h03;
	localparam logic [7:0] FN_WRITE_COIL  = 8'h05;
	localparam logic [7:0] FN_WRITE_REG   = 8'h06;

	// coil write value that turns the coil on
	localparam logic [15:0] COIL_ON = 16'hFF00;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// sequencer step addresses
	typedef logic [4:0] step_t;

	localparam step_t ST_IDLE      = 5'd0;
	localparam step_t ST_REDUCE    = 5'd1;
	localparam step_t ST_UID       = 5'd2;
	localparam step_t ST_CMD       = 5'd3;
	localparam step_t ST_RC_NBYTE  = 5'd4;
	localparam step_t ST_RC_LOAD   = 5'd5;
	localparam step_t ST_RC_LOOP   = 5'd6;
	localparam step_t ST_RC_EMIT   = 5'd7;
	localparam step_t ST_RC_CRC_LO = 5'd8;
	localparam step_t ST_RC_CRC_HI = 5'd9;
	localparam step_t ST_RR_NBYTE  = 5'd10;
	localparam step_t ST_RR_READ   = 5'd11;
	localparam step_t ST_RR_HI     = 5'd12;
	localparam step_t ST_RR_LO     = 5'd13;
	localparam step_t ST_RR_CRC_LO = 5'd14;
	localparam step_t ST_RR_CRC_HI = 5'd15;
	localparam step_t ST_W_ADDR_HI = 5'd16;
	localparam step_t ST_W_ADDR_LO = 5'd17;
	localparam step_t ST_W_VAL_HI  = 5'd18;
	localparam step_t ST_W_VAL_LO  = 5'd19;
	localparam step_t ST_W_CRC_LO  = 5'd20;
	localparam step_t ST_W_CRC_HI  = 5'd21;

	// source of the byte sent by an emitting step
	typedef enum logic [3:0] {
		SRC_UID,
		SRC_CMD,
		SRC_NBYTE,
		SRC_ADDR_HI,
		SRC_ADDR_LO,
		SRC_VAL_HI,
		SRC_VAL_LO,
		SRC_RD_HI,
		SRC_RD_LO,
		SRC_ACC,
		SRC_CRC_LO,
		SRC_CRC_HI
	} src_t;

	// datapath action of a step
	typedef enum logic [2:0] {
		OP_NONE,
		OP_DISPATCH,
		OP_REDUCE,
		OP_WRITE,
		OP_REG_RD,
		OP_COIL_LOAD,
		OP_COIL_LOOP
	} op_t;

	// branch condition; taken goes to target, else to the next step
	typedef enum logic [2:0] {
		CND_NEXT,
		CND_END,
		CND_CNT_Z,
		CND_CNT_NZ,
		CND_BITS_NZ,
		CND_RED_NZ
	} cond_t;

	typedef struct packed {
		logic  emit;
		src_t  src;
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	// bank controls from the sequencer
	typedef struct packed {
		logic reg_wr;
		logic reg_rd;
		logic coil_wr;
		logic coil_rd;
		logic coil_set;
	} bank_ctl_t;

	function automatic uword_t uw(input logic e, input src_t s, input op_t o,
			input cond_t c, input step_t t);
		uword_t w;
		w.emit   = e;
		w.src    = s;
		w.op     = o;
		w.cond   = c;
		w.target = t;
		return w;
	endfunction

	// control store
	function automatic uword_t ucode(input step_t st);
		uword_t w;
		case (st)
			ST_REDUCE:    w = uw(1'b0, SRC_UID, OP_REDUCE, CND_RED_NZ, ST_REDUCE);
			ST_UID:       w = uw(1'b1, SRC_UID, OP_NONE, CND_NEXT, ST_IDLE);
			ST_CMD:       w = uw(1'b1, SRC_CMD, OP_DISPATCH, CND_NEXT, ST_IDLE);
			// read coils
			ST_RC_NBYTE:  w = uw(1'b1, SRC_NBYTE, OP_NONE, CND_CNT_Z, ST_RC_CRC_LO);
			ST_RC_LOAD:   w = uw(1'b0, SRC_UID, OP_COIL_LOAD, CND_NEXT, ST_IDLE);
			ST_RC_LOOP:   w = uw(1'b0, SRC_UID, OP_COIL_LOOP, CND_BITS_NZ, ST_RC_LOOP);
			ST_RC_EMIT:   w = uw(1'b1, SRC_ACC, OP_NONE, CND_CNT_NZ, ST_RC_LOAD);
			ST_RC_CRC_LO: w = uw(1'b1, SRC_CRC_LO, OP_NONE, CND_NEXT, ST_IDLE);
			ST_RC_CRC_HI: w = uw(1'b1, SRC_CRC_HI, OP_NONE, CND_END, ST_IDLE);
			// read holding registers
			ST_RR_NBYTE:  w = uw(1'b1, SRC_NBYTE, OP_NONE, CND_CNT_Z, ST_RR_CRC_LO);
			ST_RR_READ:   w = uw(1'b0, SRC_UID, OP_REG_RD, CND_NEXT, ST_IDLE);
			ST_RR_HI:     w = uw(1'b1, SRC_RD_HI, OP_NONE, CND_NEXT, ST_IDLE);
			ST_RR_LO:     w = uw(1'b1, SRC_RD_LO, OP_NONE, CND_CNT_NZ, ST_RR_READ);
			ST_RR_CRC_LO: w = uw(1'b1, SRC_CRC_LO, OP_NONE, CND_NEXT, ST_IDLE);
			ST_RR_CRC_HI: w = uw(1'b1, SRC_CRC_HI, OP_NONE, CND_END, ST_IDLE);
			// single writes, echo of address and value
			ST_W_ADDR_HI: w = uw(1'b1, SRC_ADDR_HI, OP_WRITE, CND_NEXT, ST_IDLE);
			ST_W_ADDR_LO: w = uw(1'b1, SRC_ADDR_LO, OP_NONE, CND_NEXT, ST_IDLE);
			ST_W_VAL_HI:  w = uw(1'b1, SRC_VAL_HI, OP_NONE, CND_NEXT, ST_IDLE);
			ST_W_VAL_LO:  w = uw(1'b1, SRC_VAL_LO, OP_NONE, CND_NEXT, ST_IDLE);
			ST_W_CRC_LO:  w = uw(1'b1, SRC_CRC_LO, OP_NONE, CND_NEXT, ST_IDLE);
			ST_W_CRC_HI:  w = uw(1'b1, SRC_CRC_HI, OP_NONE, CND_END, ST_IDLE);
			default:      w = uw(1'b0, SRC_UID, OP_NONE, CND_END, ST_IDLE);
		endcase
		return w;
	endfunction

	function automatic logic cmd_supported(input logic [7:0] c);
		return (c == FN_READ_COILS) || (c == FN_READ_INPUTS) || (c == FN_READ_REGS) ||
			(c == FN_WRITE_COIL) || (c == FN_WRITE_REG);
	endfunction

	// one byte of the Modbus CRC-16, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

FILE: rtl/mrs_if.sv
`timescale 1ns / 1ps

// decoded request channel
interface mrs_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  slave_id;
	logic [7:0]  cmd;
	logic [15:0] address;
	logic [15:0] value;

	modport source (output valid, output slave_id, output cmd, output address,
		output value, input ready);
	modport sink (input valid, input slave_id, input cmd, input address,
		input value, output ready);
endinterface

// response byte channel
interface mrs_resp_if;
	logic       valid;
	logic       ready;
	logic [7:0] resp_byte;
	logic       last;

	modport source (output valid, output resp_byte, output last, input ready);
	modport sink (input valid, input resp_byte, input last, output ready);
endinterface

FILE: rtl/mrs_banks.sv
`timescale 1ns / 1ps

module mrs_banks #(
	parameter int REG_DEPTH = 64,
	parameter int COIL_DEPTH = 64,
	localparam int RA_W = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1,
	localparam int CA_W = $clog2(COIL_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mrs_pkg::bank_ctl_t  ctl,
	input  logic [RA_W-1:0]     reg_addr,
	input  logic [CA_W-1:0]     coil_addr,
	input  logic [15:0]         wdata,
	output logic [15:0]         reg_rdata,
	output logic                coil_rdata,
	output logic                clearing
);
	import mrs_pkg::*;

	localparam int MAXD = (REG_DEPTH > COIL_DEPTH) ? REG_DEPTH : COIL_DEPTH;
	localparam int CW = $clog2(MAXD);

	logic [15:0] regs [REG_DEPTH];
	logic        coils [COIL_DEPTH];

	logic          clearing_q;
	logic [CW-1:0] clr_cnt_q;

	assign clearing = clearing_q;

	// clearing pass after reset, one entry of each bank per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == CW'(MAXD - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// holding registers
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (32'(clr_cnt_q) < REG_DEPTH) begin
				regs[clr_cnt_q[RA_W-1:0]] <= '0;
			end
		end else begin
			if (ctl.reg_wr) begin
				regs[reg_addr] <= wdata;
			end
			if (ctl.reg_rd) begin
				reg_rdata <= regs[reg_addr];
			end
		end
	end

	// coils
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (32'(clr_cnt_q) < COIL_DEPTH) begin
				coils[clr_cnt_q[CA_W-1:0]] <= 1'b0;
			end
		end else begin
			if (ctl.coil_wr) begin
				coils[coil_addr] <= ctl.coil_set;
			end
			if (ctl.coil_rd) begin
				coil_rdata <= coils[coil_addr];
			end
		end
	end

endmodule

FILE: rtl/modbus_rtu_slave_responder.sv
`timescale 1ns / 1ps

// Modbus RTU slave responder.
// req: one decoded request item (slave_id, cmd, address, value), taken on
// valid & ready. resp: the response frame, one byte per item, CRC low byte
// then high byte, last set on the final CRC byte. cfg_we/cfg_wdata write
// unit_address (reset value 1); write it only while the block is idle.
// Requests for another unit id or an unsupported function are dropped.
// A microcoded sequencer runs one request at a time; req.ready is high only
// between requests. The first response byte, the unit id, is loaded into the
// output register by the UID step, after the accept and any reduction steps.
// Each register read is one bank read, then 2 bytes; coils are read
// bit-serially into data bytes. When a bank depth is not a power of two,
// the address is first reduced modulo the depth by restoring subtraction.
// After reset both banks are cleared, one entry per cycle; no request is
// taken meanwhile.
// A stalled receiver holds the output register; the sequencer waits at its
// next byte-emitting step until the held byte is taken.
module modbus_rtu_slave_responder #(
	parameter int REG_DEPTH = 64,
	parameter int COIL_DEPTH = 64,
	parameter int MAX_READ_REGS = 16,
	parameter int MAX_READ_COILS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	mrs_req_if.sink    req,
	mrs_resp_if.source resp
);
	import mrs_pkg::*;

	localparam int RA_W = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
	localparam int CA_W = $clog2(COIL_DEPTH);
	localparam int MAXC = (MAX_READ_COILS > MAX_READ_REGS) ? MAX_READ_COILS : MAX_READ_REGS;
	localparam int CNT_W = $clog2(MAXC + 1);
	localparam bit REG_POW2 = (REG_DEPTH & (REG_DEPTH - 1)) == 0;
	localparam bit COIL_POW2 = (COIL_DEPTH & (COIL_DEPTH - 1)) == 0;
	localparam bit NEED_RED = !(REG_POW2 && COIL_POW2);

	// control
	step_t step_q, step_d;
	logic  out_valid_q;
	logic  [7:0] unit_q;

	// datapath
	logic [7:0]       cmd_q;
	logic [15:0]      addr_q;
	logic [15:0]      val_q;
	logic [15:0]      reg_idx_q;
	logic [15:0]      coil_idx_q;
	logic [3:0]       red_k_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       nbyte_q;
	logic [15:0]      crc_q;
	logic [3:0]       bits_left_q;
	logic [2:0]       acc_pos_q;
	logic [7:0]       acc_q;
	logic             pend_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	uword_t      w;
	logic        accept, go, fire, run, out_free, is_coil_rd;
	logic [7:0]  sel_byte;
	logic [32:0] reg_trial, coil_trial;
	logic [15:0] reg_next, coil_next;
	logic [CNT_W-1:0] n_sat;
	logic [3:0]  load_bits;
	bank_ctl_t   ctl;
	logic [15:0] reg_rdata;
	logic        coil_rdata, clearing;

	assign out_free   = !out_valid_q || resp.ready;
	assign req.ready  = (step_q == ST_IDLE) && !clearing;
	assign accept     = req.valid && req.ready;
	assign resp.valid = out_valid_q;
	assign resp.resp_byte = out_byte_q;
	assign resp.last  = out_last_q;

	// request decode at accept
	always_comb begin
		go = (req.slave_id == unit_q) && cmd_supported(req.cmd);
		is_coil_rd = (req.cmd == FN_READ_COILS) || (req.cmd == FN_READ_INPUTS);
		if (is_coil_rd) begin
			n_sat = (32'(req.value) > MAX_READ_COILS) ? CNT_W'(MAX_READ_COILS)
				: req.value[CNT_W-1:0];
		end else begin
			n_sat = (32'(req.value) > MAX_READ_REGS) ? CNT_W'(MAX_READ_REGS)
				: req.value[CNT_W-1:0];
		end
	end

	// index arithmetic: reduction trial and wrap-around step
	always_comb begin
		reg_trial  = 33'(reg_idx_q) - (33'(REG_DEPTH) << red_k_q);
		coil_trial = 33'(coil_idx_q) - (33'(COIL_DEPTH) << red_k_q);
		reg_next   = (reg_idx_q == 16'(REG_DEPTH - 1)) ? 16'd0 : reg_idx_q + 16'd1;
		coil_next  = (coil_idx_q == 16'(COIL_DEPTH - 1)) ? 16'd0 : coil_idx_q + 16'd1;
		load_bits  = (32'(cnt_q) >= 8) ? 4'd8 : 4'(cnt_q);
	end

	// control word, byte select and next step
	always_comb begin
		w    = ucode(step_q);
		run  = step_q != ST_IDLE;
		fire = run && (!w.emit || out_free);

		case (w.src)
			SRC_UID:     sel_byte = unit_q;
			SRC_CMD:     sel_byte = cmd_q;
			SRC_NBYTE:   sel_byte = nbyte_q;
			SRC_ADDR_HI: sel_byte = addr_q[15:8];
			SRC_ADDR_LO: sel_byte = addr_q[7:0];
			SRC_VAL_HI:  sel_byte = val_q[15:8];
			SRC_VAL_LO:  sel_byte = val_q[7:0];
			SRC_RD_HI:   sel_byte = reg_rdata[15:8];
			SRC_RD_LO:   sel_byte = reg_rdata[7:0];
			SRC_ACC:     sel_byte = acc_q;
			SRC_CRC_LO:  sel_byte = crc_q[7:0];
			SRC_CRC_HI:  sel_byte = crc_q[15:8];
			default:     sel_byte = 8'h00;
		endcase

		step_d = step_q;
		if (!run) begin
			if (accept && go) begin
				step_d = NEED_RED ? ST_REDUCE : ST_UID;
			end
		end else if (fire) begin
			if (w.op == OP_DISPATCH) begin
				case (cmd_q)
					FN_READ_COILS, FN_READ_INPUTS: step_d = ST_RC_NBYTE;
					FN_READ_REGS:                  step_d = ST_RR_NBYTE;
					FN_WRITE_COIL, FN_WRITE_REG:   step_d = ST_W_ADDR_HI;
					default:                       step_d = ST_IDLE;
				endcase
			end else begin
				case (w.cond)
					CND_NEXT:    step_d = step_t'(step_q + 1'b1);
					CND_END:     step_d = ST_IDLE;
					CND_CNT_Z:   step_d = (cnt_q == '0) ? w.target : step_t'(step_q + 1'b1);
					CND_CNT_NZ:  step_d = (cnt_q != '0) ? w.target : step_t'(step_q + 1'b1);
					CND_BITS_NZ: step_d = (bits_left_q != '0) ? w.target
						: step_t'(step_q + 1'b1);
					CND_RED_NZ:  step_d = (red_k_q != '0) ? w.target : step_t'(step_q + 1'b1);
					default:     step_d = ST_IDLE;
				endcase
			end
		end

		// bank strobes
		ctl.reg_wr   = fire && (w.op == OP_WRITE) && (cmd_q == FN_WRITE_REG);
		ctl.coil_wr  = fire && (w.op == OP_WRITE) && (cmd_q == FN_WRITE_COIL);
		ctl.coil_set = val_q == COIL_ON;
		ctl.reg_rd   = fire && (w.op == OP_REG_RD);
		ctl.coil_rd  = fire && (w.op == OP_COIL_LOOP) && (bits_left_q != '0);
	end

	// step counter, output valid, unit address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			out_valid_q <= 1'b0;
			unit_q      <= 8'd1;
		end else begin
			step_q <= step_d;
			if (fire && w.emit) begin
				out_valid_q <= 1'b1;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unit_q <= cfg_wdata;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= req.cmd;
			addr_q     <= req.address;
			val_q      <= req.value;
			reg_idx_q  <= NEED_RED ? req.address : (req.address & 16'(REG_DEPTH - 1));
			coil_idx_q <= NEED_RED ? req.address : (req.address & 16'(COIL_DEPTH - 1));
			red_k_q    <= 4'd15;
			cnt_q      <= n_sat;
			nbyte_q    <= is_coil_rd ? 8'((32'(n_sat) + 7) >> 3) : 8'(32'(n_sat) * 2);
			crc_q      <= CRC_INIT;
		end

		if (fire) begin
			case (w.op)
				// one restoring step of address mod depth per cycle
				OP_REDUCE: begin
					if (!reg_trial[32]) begin
						reg_idx_q <= reg_trial[15:0];
					end
					if (!coil_trial[32]) begin
						coil_idx_q <= coil_trial[15:0];
					end
					red_k_q <= red_k_q - 4'd1;
				end
				OP_REG_RD: begin
					reg_idx_q <= reg_next;
					cnt_q     <= cnt_q - 1'b1;
				end
				OP_COIL_LOAD: begin
					bits_left_q <= load_bits;
					cnt_q       <= cnt_q - CNT_W'(load_bits);
					acc_q       <= 8'h00;
					acc_pos_q   <= 3'd0;
					pend_q      <= 1'b0;
				end
				// issue one coil read, collect the previous one
				OP_COIL_LOOP: begin
					if (bits_left_q != '0) begin
						coil_idx_q  <= coil_next;
						bits_left_q <= bits_left_q - 4'd1;
					end
					pend_q <= bits_left_q != '0;
					if (pend_q) begin
						acc_q[acc_pos_q] <= coil_rdata;
						acc_pos_q        <= acc_pos_q + 3'd1;
					end
				end
				default: ;
			endcase

			if (w.emit) begin
				out_byte_q <= sel_byte;
				out_last_q <= w.src == SRC_CRC_HI;
				if (w.src != SRC_CRC_LO && w.src != SRC_CRC_HI) begin
					crc_q <= crc_byte(crc_q, sel_byte);
				end
			end
		end
	end

	mrs_banks #(
		.REG_DEPTH (REG_DEPTH),
		.COIL_DEPTH(COIL_DEPTH)
	) u_banks (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.reg_addr  (reg_idx_q[RA_W-1:0]),
		.coil_addr (coil_idx_q[CA_W-1:0]),
		.wdata     (val_q),
		.reg_rdata (reg_rdata),
		.coil_rdata(coil_rdata),
		.clearing  (clearing)
	);

endmodule

FILE: tb/modbus_rtu_slave_responder_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register-write ports, keeps its own copy of
// the coil and holding-register banks, and checks every response byte in order.
module modbus_rtu_slave_responder_checker #(
	parameter int REG_DEPTH = 64,
	parameter int COIL_DEPTH = 64,
	parameter int MAX_READ_REGS = 16,
	parameter int MAX_READ_COILS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	mrs_req_if         req,
	mrs_resp_if        resp,
	output int         fails,
	output int         pending,
	output int         requests,
	output int         answered,
	output int         bytes_checked
);
	import mrs_pkg::*;

	typedef struct packed {
		logic [7:0] resp_byte;
		logic       last;
	} frame_byte_t;

	logic [15:0] holding [REG_DEPTH];
	logic        coils [COIL_DEPTH];
	logic [7:0]  unit_addr;
	frame_byte_t frame_bytes_due [$];

	// bit-serial Modbus CRC-16, data LSB first
	function automatic logic [15:0] crc16_shift_in(input logic [15:0] crc,
			input logic [7:0] data);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			fb = c[0] ^ data[k];
			c = c >> 1;
			if (fb) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	// builds the reply frame of one request and applies its bank write
	function automatic void answer_request(input logic [7:0] sid, input logic [7:0] cmd,
			input logic [15:0] addr, input logic [15:0] val);
		logic [7:0]  body [$];
		logic [7:0]  bits8;
		logic [15:0] word;
		logic [15:0] crc;
		int          n;
		if (sid != unit_addr) return;
		body.push_back(unit_addr);
		body.push_back(cmd);
		case (cmd)
			FN_READ_COILS, FN_READ_INPUTS: begin
				n = (int'(val) > MAX_READ_COILS) ? MAX_READ_COILS : int'(val);
				body.push_back(8'((n + 7) / 8));
				bits8 = '0;
				// coils packed LSB first, partial last byte zero-filled
				for (int i = 0; i < n; i++) begin
					bits8[i % 8] = coils[(int'(addr) + i) % COIL_DEPTH];
					if (i % 8 == 7 || i == n - 1) begin
						body.push_back(bits8);
						bits8 = '0;
					end
				end
			end
			FN_READ_REGS: begin
				n = (int'(val) > MAX_READ_REGS) ? MAX_READ_REGS : int'(val);
				body.push_back(8'(n * 2));
				for (int i = 0; i < n; i++) begin
					word = holding[(int'(addr) + i) % REG_DEPTH];
					body.push_back(word[15:8]);
					body.push_back(word[7:0]);
				end
			end
			FN_WRITE_COIL, FN_WRITE_REG: begin
				if (cmd == FN_WRITE_COIL) coils[int'(addr) % COIL_DEPTH] = (val == COIL_ON);
				else holding[int'(addr) % REG_DEPTH] = val;
				// echo carries the address as received, not wrapped
				body.push_back(addr[15:8]);
				body.push_back(addr[7:0]);
				body.push_back(val[15:8]);
				body.push_back(val[7:0]);
			end
			default: return;
		endcase
		crc = CRC_INIT;
		foreach (body[k]) crc = crc16_shift_in(crc, body[k]);
		body.push_back(crc[7:0]);
		body.push_back(crc[15:8]);
		foreach (body[k]) frame_bytes_due.push_back(frame_byte_t'{body[k], k == body.size() - 1});
		answered++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_byte_t due;
		if (!arst_n) begin
			foreach (holding[i]) holding[i] = '0;
			foreach (coils[i]) coils[i] = 1'b0;
			unit_addr = 8'h01;
			frame_bytes_due.delete();
			fails = 0;
			requests = 0;
			answered = 0;
			bytes_checked = 0;
		end else begin
			// register write
			if (cfg_we) unit_addr = cfg_wdata;
			// accepted request
			if (req.valid && req.ready) begin
				requests++;
				answer_request(req.slave_id, req.cmd, req.address, req.value);
			end
			// accepted response item
			if (resp.valid && resp.ready) begin
				if (frame_bytes_due.size() == 0) begin
					$error("response item with none expected: resp_byte %h, last %b",
						resp.resp_byte, resp.last);
					fails++;
				end else begin
					due = frame_bytes_due.pop_front();
					if (resp.resp_byte !== due.resp_byte) begin
						$error("resp_byte mismatch: expected %h, got %h",
							due.resp_byte, resp.resp_byte);
						fails++;
					end
					if (resp.last !== due.last) begin
						$error("last mismatch: expected %b, got %b", due.last, resp.last);
						fails++;
					end
					bytes_checked++;
				end
			end
		end
		pending = frame_bytes_due.size();
	end

endmodule

FILE: tb/modbus_rtu_slave_responder_test.sv
`timescale 1ns / 1ps

module modbus_rtu_slave_responder_test;
	import mrs_pkg::*;

	localparam int REG_DEPTH = 64;
	localparam int COIL_DEPTH = 64;
	localparam int MAX_READ_REGS = 16;
	localparam int MAX_READ_COILS = 64;
	localparam int HALF_PERIOD = 5;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ANSWERS_PER_PHASE = 92;
	// idle cycles after the last byte before touching the unit address
	localparam int SETTLE_CYCLES = 8;

	localparam logic [7:0] SERVED_FN [5] = '{FN_READ_COILS, FN_READ_INPUTS, FN_READ_REGS,
		FN_WRITE_COIL, FN_WRITE_REG};
	localparam logic [7:0] UNSERVED_FN [4] = '{8'h00, 8'h04, 8'h07, 8'hFF};

	typedef struct {
		logic [7:0]  slave_id;
		logic [7:0]  cmd;
		logic [15:0] address;
		logic [15:0] value;
	} request_t;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	mrs_req_if  req ();
	mrs_resp_if resp ();

	int         fails;
	int         pending;
	int         requests;
	int         answered;
	int         bytes_checked;
	int         cycles = 0;
	int         burst_left = 0;
	int         settings = 1;
	logic       req_held = 1'b0;
	logic [7:0] unit_addr = 8'h01;

	modbus_rtu_slave_responder #(
		.REG_DEPTH(REG_DEPTH),
		.COIL_DEPTH(COIL_DEPTH),
		.MAX_READ_REGS(MAX_READ_REGS),
		.MAX_READ_COILS(MAX_READ_COILS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.resp(resp)
	);

	modbus_rtu_slave_responder_checker #(
		.REG_DEPTH(REG_DEPTH),
		.COIL_DEPTH(COIL_DEPTH),
		.MAX_READ_REGS(MAX_READ_REGS),
		.MAX_READ_COILS(MAX_READ_COILS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.resp(resp),
		.fails(fails),
		.pending(pending),
		.requests(requests),
		.answered(answered),
		.bytes_checked(bytes_checked)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: ready pattern switches at random among always, random, sparse and periodic modes
	initial begin : receiver
		rx_mode_e mode;
		int       left;
		int       tick;
		resp.ready = 1'b0;
		mode = RX_ALWAYS;
		left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = rx_mode_e'($urandom_range(0, 3));
				left = $urandom_range(20, 300);
			end
			left--;
			tick++;
			case (mode)
				RX_ALWAYS:   resp.ready <= 1'b1;
				RX_RANDOM:   resp.ready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE:   resp.ready <= (tick % 5 < 2);
				RX_PERIODIC: resp.ready <= (tick % 11 != 0);
				default:     resp.ready <= 1'b1;
			endcase
		end
	end

	task automatic release_req();
		if (req_held) begin
			req.valid <= 1'b0;
			req_held = 1'b0;
		end
	endtask

	// one request item; returns on the falling edge after acceptance
	task automatic send_request(input logic [7:0] sid, input logic [7:0] cmd,
			input logic [15:0] addr, input logic [15:0] val);
		req.valid <= 1'b1;
		req.slave_id <= sid;
		req.cmd <= cmd;
		req.address <= addr;
		req.value <= val;
		req_held = 1'b1;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		// bursts of back-to-back items, random gaps between them
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			release_req();
			repeat ($urandom_range(1, 40)) @(negedge clk);
			burst_left = $urandom_range(0, 10);
		end
	endtask

	// hold off until every response byte is in and the block is idle
	task automatic wait_idle();
		release_req();
		burst_left = 0;
		wait (pending == 0);
		do @(posedge clk); while (!req.ready);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_unit_address(input logic [7:0] addr);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= addr;
		@(negedge clk);
		cfg_we <= 1'b0;
		unit_addr = addr;
		settings++;
	endtask

	// mostly well-formed requests to our unit, some foreign ids and bad functions
	function automatic request_t pick_request();
		request_t r;
		int       roll;
		roll = $urandom_range(0, 99);
		r.slave_id = unit_addr;
		r.cmd = SERVED_FN[$urandom_range(0, 4)];
		r.address = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
		r.value = 16'($urandom);
		if (roll < 7) begin
			r.slave_id = 8'($urandom);
		end else if (roll < 13) begin
			do r.cmd = 8'($urandom);
			while (r.cmd inside {FN_READ_COILS, FN_READ_INPUTS, FN_READ_REGS,
				FN_WRITE_COIL, FN_WRITE_REG});
		end
		// keep read counts near the saturation points most of the time
		case (r.cmd)
			FN_READ_COILS, FN_READ_INPUTS:
				if ($urandom_range(0, 7) != 0) r.value = 16'($urandom_range(0, 66));
			FN_READ_REGS:
				if ($urandom_range(0, 7) != 0) r.value = 16'($urandom_range(0, 18));
			FN_WRITE_COIL:
				if ($urandom_range(0, 1) == 0) r.value = COIL_ON;
			default: ;
		endcase
		return r;
	endfunction

	initial begin : stimulus
		request_t r;
		int       target;
		logic [7:0] phase_addr [4];
		req.valid = 1'b0;
		req.slave_id = 8'h00;
		req.cmd = 8'h00;
		req.address = 16'h0000;
		req.value = 16'h0000;
		phase_addr = '{8'h00, 8'hFF, 8'($urandom_range(2, 254)), 8'h01};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, wraps, saturation, zero counts, drops
		send_request(8'h01, FN_READ_REGS, 16'h0000, 16'h0000);
		send_request(8'h01, FN_WRITE_REG, 16'h0000, 16'hFFFF);
		send_request(8'h01, FN_WRITE_REG, 16'hFFFF, 16'h8001);
		send_request(8'h01, FN_WRITE_REG, 16'h0041, 16'h0000);
		send_request(8'h01, FN_READ_REGS, 16'hFFFF, 16'h0003);
		send_request(8'h01, FN_READ_REGS, 16'h0000, 16'hFFFF);
		send_request(8'h01, FN_READ_REGS, 16'h003F, 16'h0011);
		send_request(8'h01, FN_WRITE_COIL, 16'h0000, COIL_ON);
		send_request(8'h01, FN_WRITE_COIL, 16'hFFFF, COIL_ON);
		send_request(8'h01, FN_WRITE_COIL, 16'h0009, COIL_ON);
		send_request(8'h01, FN_WRITE_COIL, 16'h0009, 16'hFF01);
		send_request(8'h01, FN_WRITE_COIL, 16'h0048, 16'h00FF);
		send_request(8'h01, FN_WRITE_COIL, 16'h8007, COIL_ON);
		send_request(8'h01, FN_READ_COILS, 16'h003E, 16'h0003);
		send_request(8'h01, FN_READ_INPUTS, 16'h0000, 16'hFFFF);
		send_request(8'h01, FN_READ_COILS, 16'h0000, 16'h0000);
		send_request(8'h01, FN_READ_INPUTS, 16'h0000, 16'h0009);
		send_request(8'h01, FN_READ_COILS, 16'h0001, 16'h0041);
		send_request(8'hFE, FN_READ_REGS, 16'h0000, 16'h0001);
		send_request(8'h00, FN_WRITE_REG, 16'h0000, 16'h1234);
		foreach (UNSERVED_FN[i]) send_request(8'h01, UNSERVED_FN[i], 16'h0000, 16'h0001);
		// the foreign write above must not have landed
		send_request(8'h01, FN_READ_REGS, 16'h0000, 16'h0002);

		// random phases, one per unit address setting
		foreach (phase_addr[p]) begin
			set_unit_address(phase_addr[p]);
			target = answered + ANSWERS_PER_PHASE;
			while (answered < target) begin
				r = pick_request();
				send_request(r.slave_id, r.cmd, r.address, r.value);
			end
		end

		wait_idle();
		$display("%0d requests sent, %0d answered, %0d dropped, over %0d unit addresses",
			requests, answered, requests - answered, settings);
		$display("%0d response items compared against predicted frames", bytes_checked);
		if (fails == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
